// ----- src/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int KEY_W       = 16;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  borrower;
        logic [ID_W-1:0]  book;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted chain: holds, loads the new entry, or shifts.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_stays,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_stays
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_stays = i_occ && (r_entry.key <= i_new.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_stays) begin
                n_entry = r_entry;
            end else if (i_left_stays) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- src/stable_priority_queue_core.sv -----
// Top level of the stable priority queue: chain of sorted slots and result register.
//
// Input channel s_axis: tuser carries the opcode (insert or remove), tdata carries
// borrower id, book id and priority key. Output channel m_axis: tdata carries the
// status, borrower id and book id of one result per accepted item.
// For each item all slots compare their key with the incoming key in
// parallel and every slot holds, loads the new entry or shifts by one in the same
// edge. The result appears in the output register in the cycle after the transfer.
// Up to one item per cycle is taken; the rate is set by the single output register,
// since s_axis_tready is high only while that register is empty or being drained.
// Inserts into a full queue are dropped with status full; a remove on an empty
// queue returns status empty with zero ids. Entries with equal keys leave in
// arrival order.
// Reset (i_rst_n low, synchronous) empties the queue and clears the output valid;
// slot contents are not cleared and are never read before being written.
// When the receiver stalls, the result is held in the output register and no new
// item is taken until it transfers.
module stable_priority_queue_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [47:0] borrower_in [15:0], book_in [31:16], key_in [47:32]
    input  logic [spq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status [1:0], borrower_out [17:2], book_out [33:18], zero [39:34]
    output logic [spq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import spq_pkg::*;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_opcode            w_op;
    t_entry             w_new;
    t_cell_ctl          w_ctl;
    t_entry             w_entry [QUEUE_DEPTH];
    logic               w_stays [QUEUE_DEPTH];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_status            r_status;
    logic [ID_W-1:0]    r_borrower;
    logic [ID_W-1:0]    r_book;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_opcode'(s_axis_tuser);
    assign w_new.borrower = s_axis_tdata[15:0];
    assign w_new.book     = s_axis_tdata[31:16];
    assign w_new.key      = s_axis_tdata[47:32];
    assign w_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_ctl.ins     = w_accept && (w_op == OP_INSERT) && !w_full;
    assign w_ctl.rem     = w_accept && (w_op == OP_REMOVE) && !w_empty;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (CNT_W'(i) < r_count),
            .i_new       (w_new),
            .i_left      ((i == 0) ? w_new : w_entry[(i == 0) ? 0 : i - 1]),
            .i_left_stays((i == 0) ? 1'b1 : w_stays[(i == 0) ? 0 : i - 1]),
            .i_right     (w_entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .o_entry     (w_entry[i]),
            .o_stays     (w_stays[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_borrower <= '0;
            r_book     <= '0;
            r_status   <= ST_DONE;
            if (w_op == OP_INSERT) begin
                if (w_full) begin
                    r_status <= ST_FULL;
                end
            end else if (w_empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_borrower <= w_entry[0].borrower;
                r_book     <= w_entry[0].book;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_book, r_borrower, r_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_op == OP_INSERT) && w_full |=> $stable(r_count))
        else $error("dropped insert changed fill count");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not decrement fill count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("no result after transfer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_status != ST_DONE) |-> r_borrower == '0 && r_book == '0)
        else $error("nonzero ids on failed operation");

endmodule
